/* hdl/csrc_pkg.sv */
// shared types, constants and the base complement table for the canonical
// reverse-complement block; no dependencies
package csrc_pkg;

	// default buffer depth in characters
	localparam int unsigned MAX_LEN_DEF = 64;

	// controller states
	typedef enum logic [2:0] {
		ST_LOAD,
		ST_CMP_RD,
		ST_CMP_EV,
		ST_EMIT_RD,
		ST_EMIT_OUT
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;      // store the accepted word, update length and overflow
		logic rd_cmp;    // read forward and backward entries for comparison
		logic rd_emit;   // read the entry for the next emitted word
		logic idx_clr;   // restart the walk index
		logic idx_inc;   // advance the walk index
		logic set_rc;    // latch the orientation choice
		logic rc_val;    // orientation value: 1 reverse complement
		logic seq_clr;   // sequence done, clear length and overflow
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic canonical; // canonical mode register
		logic idx_last;  // walk index sits on the last stored character
		logic cmp_lt;    // original byte below complement byte
		logic cmp_gt;    // original byte above complement byte
	} status_t;

	// upper-case complement of an iupac code, either case; unknown gives N
	function automatic logic [7:0] comp_base(input logic [7:0] c);
		logic [7:0] r;
		case (c) inside
			"A", "a":           r = "T";
			"C", "c":           r = "G";
			"G", "g":           r = "C";
			"T", "t", "U", "u": r = "A";
			"M", "m":           r = "K";
			"R", "r":           r = "Y";
			"W", "w":           r = "W";
			"S", "s":           r = "S";
			"Y", "y":           r = "R";
			"K", "k":           r = "M";
			"V", "v":           r = "B";
			"H", "h":           r = "D";
			"D", "d":           r = "H";
			"B", "b":           r = "V";
			default:            r = "N";
		endcase
		return r;
	endfunction

endpackage

/* hdl/csrc_ctrl.sv */
// controller state machine for the canonical reverse-complement block
// depends on csrc_pkg for state, command and status types
module csrc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               end_of_sequence,
	input  logic               out_stall,
	input  csrc_pkg::status_t  st,
	output csrc_pkg::cmd_t     cmd,
	output logic               in_stall,
	output logic               out_valid
);
	import csrc_pkg::*;

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (end_of_sequence) begin
						cmd.idx_clr = 1'b1;
						if (st.canonical) begin
							state_d = ST_CMP_RD;
						end else begin
							cmd.set_rc = 1'b1;
							cmd.rc_val = 1'b1;
							state_d    = ST_EMIT_RD;
						end
					end
				end
			end
			ST_CMP_RD: begin
				cmd.rd_cmp = 1'b1;
				state_d    = ST_CMP_EV;
			end
			ST_CMP_EV: begin
				// first differing byte decides; equal strings take the complement
				if (st.cmp_lt) begin
					cmd.set_rc  = 1'b1;
					cmd.rc_val  = 1'b0;
					cmd.idx_clr = 1'b1;
					state_d     = ST_EMIT_RD;
				end else if (st.cmp_gt || st.idx_last) begin
					cmd.set_rc  = 1'b1;
					cmd.rc_val  = 1'b1;
					cmd.idx_clr = 1'b1;
					state_d     = ST_EMIT_RD;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = ST_CMP_RD;
				end
			end
			ST_EMIT_RD: begin
				cmd.rd_emit = 1'b1;
				state_d     = ST_EMIT_OUT;
			end
			ST_EMIT_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					if (st.idx_last) begin
						cmd.seq_clr = 1'b1;
						state_d     = ST_LOAD;
					end else begin
						cmd.idx_inc = 1'b1;
						state_d     = ST_EMIT_RD;
					end
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

endmodule

/* hdl/csrc_dp.sv */
// datapath of the canonical reverse-complement block: character buffer,
// length and overflow tracking, walk index, comparison and output word
// depends on csrc_pkg for command and status types and the complement table
module csrc_dp #(
	parameter int unsigned MAX_LEN = csrc_pkg::MAX_LEN_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  csrc_pkg::cmd_t     cmd,
	input  logic               cfg_wr_en,
	input  logic               cfg_wr_data,
	input  logic [7:0]         base_char,
	output csrc_pkg::status_t  st,
	output logic [7:0]         out_char,
	output logic               used_complement,
	output logic               length_overflow
);
	import csrc_pkg::*;

	localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int unsigned CW = $clog2(MAX_LEN + 1);

	logic [7:0]    mem [MAX_LEN];
	logic [CW-1:0] len_q;
	logic          ovf_q;
	logic [AW-1:0] idx_q;
	logic          use_rc_q;
	logic          canonical_q;
	logic [7:0]    rd_a_q;
	logic [7:0]    rd_b_q;

	logic          room;
	logic [AW-1:0] last_idx;
	logic [AW-1:0] rev_idx;
	logic [AW-1:0] addr_a;
	logic [7:0]    comp_b;

	assign room     = (len_q < CW'(MAX_LEN));
	assign last_idx = AW'(len_q - CW'(1));
	assign rev_idx  = last_idx - idx_q;
	// forward index, or backward index while emitting the complement
	assign addr_a   = (cmd.rd_emit && use_rc_q) ? rev_idx : idx_q;

	// buffer write
	always_ff @(posedge clk) begin
		if (cmd.load && room) begin
			mem[len_q[AW-1:0]] <= base_char;
		end
	end

	// registered buffer reads; rd_a_q doubles as the output word register
	always_ff @(posedge clk) begin
		if (cmd.rd_cmp || cmd.rd_emit) begin
			rd_a_q <= mem[addr_a];
		end
		if (cmd.rd_cmp) begin
			rd_b_q <= mem[rev_idx];
		end
	end

	// length and overflow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.seq_clr) begin
			len_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.load) begin
			if (room) begin
				len_q <= CW'(len_q + CW'(1));
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	// walk index and orientation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			use_rc_q <= 1'b1;
		end else begin
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= AW'(idx_q + AW'(1));
			end
			if (cmd.set_rc) begin
				use_rc_q <= cmd.rc_val;
			end
		end
	end

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			canonical_q <= 1'b1;
		end else if (cfg_wr_en) begin
			canonical_q <= cfg_wr_data;
		end
	end

	// status and output word
	assign comp_b          = comp_base(rd_b_q);
	assign st.canonical    = canonical_q;
	assign st.idx_last     = (idx_q == last_idx);
	assign st.cmp_lt       = (rd_a_q < comp_b);
	assign st.cmp_gt       = (rd_a_q > comp_b);
	assign out_char        = use_rc_q ? comp_base(rd_a_q) : rd_a_q;
	assign used_complement = use_rc_q;
	assign length_overflow = ovf_q;

	// length never passes the buffer depth
	assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= CW'(MAX_LEN))
		else $error("stored length beyond buffer depth");

	// overflow is only ever seen with a full buffer
	assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (len_q == CW'(MAX_LEN)))
		else $error("overflow flagged with room left");

	// reads only happen over a non-empty sequence
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rd_emit || cmd.rd_cmp) |-> (len_q != '0))
		else $error("buffer read with empty sequence");

	// walk index stays inside the stored characters while reading
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rd_emit || cmd.rd_cmp) |-> (CW'(idx_q) < len_q))
		else $error("walk index beyond stored length");

endmodule

/* hdl/canonical_sequence_revcomp.sv */
// Canonical reverse-complement unit. Characters arrive on the input channel
// one word per cycle while in_stall is low and are stored in a MAX_LEN-byte
// buffer; the word with end_of_sequence closes the sequence. Characters past
// MAX_LEN are dropped and length_overflow is raised on every emitted word of
// that sequence. With canonical_mode set (reset value) the original is
// compared byte by byte with its reverse complement and the strictly smaller
// one is emitted, ties giving the complement; with canonical_mode clear the
// complement is always emitted. The comparison steps through a read and an
// evaluate state per position up to the first differing byte, and emission
// through a read and an output state per word, held by any output stall; the
// single buffer memory and its registered read set these steps. The input is
// stalled from the closing word until the last word is delivered.
// canonical_mode may only be written while the block is idle.
// depends on csrc_pkg, csrc_ctrl and csrc_dp
module canonical_sequence_revcomp #(
	parameter int unsigned MAX_LEN = csrc_pkg::MAX_LEN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] base_char,
	input  logic       end_of_sequence,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_char,
	output logic       out_last,
	output logic       used_complement,
	output logic       length_overflow
);
	import csrc_pkg::*;

	cmd_t    cmd;
	status_t st;

	// controller
	csrc_ctrl u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.end_of_sequence (end_of_sequence),
		.out_stall       (out_stall),
		.st              (st),
		.cmd             (cmd),
		.in_stall        (in_stall),
		.out_valid       (out_valid)
	);

	// datapath
	csrc_dp #(
		.MAX_LEN (MAX_LEN)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.base_char       (base_char),
		.st              (st),
		.out_char        (out_char),
		.used_complement (used_complement),
		.length_overflow (length_overflow)
	);

	// last word of the sequence
	assign out_last = st.idx_last;

endmodule
